// ===== hdl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define PPC_ASSERT(name, clk_sig, rst_sig, prop) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
        else $error("assertion failed");

// condition must never be seen at a clock edge out of reset
`define PPC_NEVER(name, clk_sig, rst_sig, cond) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(cond)) \
        else $error("forbidden condition seen");

`else

`define PPC_ASSERT(name, clk_sig, rst_sig, prop)
`define PPC_NEVER(name, clk_sig, rst_sig, cond)

`endif

`endif

// ===== hdl/ppc_pkg.sv =====
// shared types, constants and pattern field helpers of the packet pattern classifier
`default_nettype none

package ppc_pkg;

    localparam int MAX_PACKET    = 64;
    localparam int PATTERN_BYTES = 6;
    localparam int QUEUE_DEPTH   = 8;
    localparam int COMMAND_BITS  = 8;

    localparam int NPAT      = 5;
    localparam int PAT_W     = 60;
    localparam int OFF_W     = 6;
    localparam int LEN_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int POS_W     = $clog2(MAX_PACKET + 1);
    localparam int SUM_W     = 8;
    localparam int SEL_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int Q_IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int LINK_DEPTH = 2;
    localparam int LINK_IDX_W = $clog2(LINK_DEPTH);
    localparam int LINK_CNT_W = $clog2(LINK_DEPTH + 1);

    localparam int P_DEV = 0;
    localparam int P_SUB = 1;
    localparam int P_OFF = 2;
    localparam int P_ON  = 3;
    localparam int P_RSP = 4;

    typedef logic [PAT_W-1:0] pattern_t;
    typedef logic [NPAT-1:0][PAT_W-1:0] pat_array_t;

    typedef enum logic [1:0] {
        ACT_BYTE = 2'd0,
        ACT_PUSH = 2'd1,
        ACT_POP  = 2'd2,
        ACT_ACK  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_VERDICT = 3'd1,
        KIND_POPPED  = 3'd2,
        KIND_NO_CMD  = 3'd3,
        KIND_DROPPED = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        VERD_BUSY     = 3'd0,
        VERD_NOT_ADDR = 3'd1,
        VERD_OFF      = 3'd2,
        VERD_ON       = 3'd3,
        VERD_OTHER    = 3'd4
    } verdict_t;

    // decoded item handed from front to back
    typedef struct packed {
        action_t                 action;
        logic                    last;
        logic [COMMAND_BITS-1:0] cmd;
        logic [NPAT-1:0]         matched;
    } op_t;

    typedef struct packed {
        kind_t                   kind;
        verdict_t                verdict;
        logic [COMMAND_BITS-1:0] cmd;
        logic                    pending;
        logic                    resp;
        logic [COUNT_W-1:0]      count;
    } res_t;

    function automatic logic [OFF_W-1:0] pat_off(input pattern_t p);
        return p[53:48];
    endfunction

    function automatic logic [LEN_W-1:0] pat_len(input pattern_t p);
        logic [LEN_W-1:0] n;
        n = p[56:54];
        return (n > LEN_W'(PATTERN_BYTES)) ? LEN_W'(PATTERN_BYTES) : n;
    endfunction

    function automatic logic [BYTE_W-1:0] pat_byte(input pattern_t p, input logic [SEL_W-1:0] i);
        logic [BYTE_W-1:0] b;
        b = '0;
        for (int j = 0; j < PATTERN_BYTES; j++)
        begin
            if (i == SEL_W'(j))
            begin
                b = p[BYTE_W*j +: BYTE_W];
            end
        end
        return b;
    endfunction

    function automatic logic pat_and(input pattern_t p);
        return p[57];
    endfunction

    function automatic logic pat_inv(input pattern_t p);
        return p[58];
    endfunction

    function automatic logic pat_en(input pattern_t p);
        return p[59];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ppc_front.sv =====
// front part: byte tracking and on-the-fly pattern matching, item decode
`default_nettype none

module ppc_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [1:0]                  action,
    input  wire logic [ppc_pkg::BYTE_W-1:0]  data_byte,
    input  wire logic                        last_byte,
    input  wire logic [ppc_pkg::COMMAND_BITS-1:0] command_id,
    input  wire ppc_pkg::pat_array_t         patterns,
    output ppc_pkg::op_t                     op
);
    import ppc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [NPAT-1:0]  exact_ok_reg, exact_ok_next;
    logic [NPAT-1:0]  mask_hit_reg, mask_hit_next;
    logic [NPAT-1:0]  ok_new, mh_new, matched;
    logic             in_range;
    logic [SUM_W-1:0] size_s;

    assign in_range = pos_reg < POS_W'(MAX_PACKET);
    assign size_s   = SUM_W'(pos_reg) + SUM_W'(in_range);

    always_comb
    begin
        logic [OFF_W-1:0]  off;
        logic [LEN_W-1:0]  len;
        logic              and_m;
        logic              inv;
        logic [SUM_W-1:0]  pos_s;
        logic [SUM_W-1:0]  off_s;
        logic [SUM_W-1:0]  end_s;
        logic [SEL_W-1:0]  rel;
        logic [BYTE_W-1:0] v;
        logic              any;
        logic              miss;
        logic              hit;
        for (int k = 0; k < NPAT; k++)
        begin
            off   = pat_off(patterns[k]);
            len   = pat_len(patterns[k]);
            and_m = pat_and(patterns[k]);
            inv   = pat_inv(patterns[k]);
            pos_s = SUM_W'(pos_reg);
            off_s = SUM_W'(off);
            end_s = off_s + SUM_W'(len);
            rel   = SEL_W'(pos_s - off_s);
            miss  = in_range && !and_m && (pos_s >= off_s) && (pos_s < end_s)
                    && (pat_byte(patterns[k], rel) != data_byte);
            v   = data_byte & pat_byte(patterns[k], SEL_W'(0));
            any = 1'b0;
            for (int i = 1; i < PATTERN_BYTES; i++)
            begin
                if ((LEN_W'(i) < len) && (v == pat_byte(patterns[k], SEL_W'(i))))
                begin
                    any = 1'b1;
                end
            end
            hit = in_range && and_m && (pos_s == off_s) && (len != '0)
                  && ((len == LEN_W'(1)) ? (v != '0) : any);
            ok_new[k] = exact_ok_reg[k] & ~miss;
            mh_new[k] = mask_hit_reg[k] | hit;
            if (!and_m)
            begin
                matched[k] = ((end_s <= size_s) && ok_new[k]) ^ inv;
            end
            else
            begin
                matched[k] = (len != '0) && (size_s > off_s) && (mh_new[k] ^ inv);
            end
        end
    end

    always_comb
    begin
        pos_next      = pos_reg;
        exact_ok_next = exact_ok_reg;
        mask_hit_next = mask_hit_reg;
        if (accept && (action_t'(action) == ACT_BYTE))
        begin
            if (last_byte)
            begin
                pos_next      = '0;
                exact_ok_next = '1;
                mask_hit_next = '0;
            end
            else
            begin
                pos_next      = in_range ? pos_reg + 1'b1 : pos_reg;
                exact_ok_next = ok_new;
                mask_hit_next = mh_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            exact_ok_reg <= '1;
            mask_hit_reg <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            exact_ok_reg <= exact_ok_next;
            mask_hit_reg <= mask_hit_next;
        end
    end

    always_comb
    begin
        op.action  = action_t'(action);
        op.last    = last_byte;
        op.cmd     = command_id;
        op.matched = matched;
    end

endmodule

`default_nettype wire

// ===== hdl/ppc_link.sv =====
// short item queue between front and back
`default_nettype none

module ppc_link (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire ppc_pkg::op_t push_op,
    output logic              full,
    input  wire logic         pop,
    output logic              head_valid,
    output ppc_pkg::op_t      head_op
);
    import ppc_pkg::*;

    op_t                   entry_reg [LINK_DEPTH];
    logic [LINK_IDX_W-1:0] rd_reg, rd_next;
    logic [LINK_IDX_W-1:0] wr_reg, wr_next;
    logic [LINK_CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = cnt_reg == LINK_CNT_W'(LINK_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_op    = entry_reg[rd_reg];

    always_comb
    begin
        rd_next  = rd_reg;
        wr_next  = wr_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == LINK_IDX_W'(LINK_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == LINK_IDX_W'(LINK_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ppc_back.sv =====
// back part: verdict, command fifo, pending and response flags, result register
`default_nettype none

module ppc_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              op_valid,
    input  wire ppc_pkg::op_t      op,
    output logic                   op_pop,
    input  wire logic [ppc_pkg::NPAT-1:0] enable,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output ppc_pkg::res_t          res
);
    import ppc_pkg::*;

    logic [COMMAND_BITS-1:0] fifo_mem [QUEUE_DEPTH];
    logic [Q_IDX_W-1:0]      head_reg, head_next;
    logic [Q_IDX_W-1:0]      tail_reg, tail_next;
    logic [COUNT_W-1:0]      fill_reg, fill_next;
    logic                    tx_reg, tx_next;
    logic                    rx_reg, rx_next;
    logic                    wr_en;
    logic                    valid_reg, valid_next;
    res_t                    res_reg, res_next;

    assign op_pop = op_valid && (!valid_reg || !res_stall);

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        fill_next        = fill_reg;
        tx_next          = tx_reg;
        rx_next          = rx_reg;
        wr_en            = 1'b0;
        res_next         = res_reg;
        res_next.kind    = KIND_NONE;
        res_next.verdict = VERD_BUSY;
        res_next.cmd     = '0;
        unique case (op.action)
            ACT_BYTE:
            begin
                if (op.last)
                begin
                    res_next.kind = KIND_VERDICT;
                    if (tx_reg)
                    begin
                        res_next.verdict = VERD_BUSY;
                    end
                    else
                    begin
                        rx_next = enable[P_RSP] && op.matched[P_RSP];
                        if (!op.matched[P_DEV])
                        begin
                            res_next.verdict = VERD_NOT_ADDR;
                        end
                        else if (enable[P_SUB] && !op.matched[P_SUB])
                        begin
                            res_next.verdict = VERD_NOT_ADDR;
                        end
                        else if (enable[P_OFF] && op.matched[P_OFF])
                        begin
                            res_next.verdict = VERD_OFF;
                        end
                        else if (enable[P_ON] && op.matched[P_ON])
                        begin
                            res_next.verdict = VERD_ON;
                        end
                        else
                        begin
                            res_next.verdict = VERD_OTHER;
                        end
                    end
                end
            end
            ACT_PUSH:
            begin
                tx_next = 1'b1;
                if (fill_reg >= COUNT_W'(QUEUE_DEPTH))
                begin
                    res_next.kind = KIND_DROPPED;
                end
                else
                begin
                    wr_en     = 1'b1;
                    tail_next = (tail_reg == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
            ACT_POP:
            begin
                if (enable[P_RSP] && !rx_reg)
                begin
                    res_next.kind = KIND_NO_CMD;
                end
                else
                begin
                    rx_next = 1'b0;
                    if (fill_reg == '0)
                    begin
                        res_next.kind = KIND_NO_CMD;
                    end
                    else
                    begin
                        res_next.kind = KIND_POPPED;
                        res_next.cmd  = fifo_mem[head_reg];
                        head_next = (head_reg == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                        fill_next = fill_reg - 1'b1;
                    end
                end
            end
            ACT_ACK:
            begin
                tx_next = fill_reg != '0;
            end
        endcase
        res_next.pending = tx_next;
        res_next.resp    = rx_next;
        res_next.count   = fill_next;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (!valid_reg || !res_stall)
        begin
            valid_next = op_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
            tx_reg    <= 1'b0;
            rx_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (op_pop)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                fill_reg <= fill_next;
                tx_reg   <= tx_next;
                rx_reg   <= rx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            res_reg <= res_next;
            if (wr_en)
            begin
                fifo_mem[tail_reg] <= op.cmd;
            end
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== hdl/packet_pattern_classifier_top.sv =====
// an accepted item is written into the link queue; its result is then registered in the result register of the back
// throughput: one item per cycle while in_stall is low; a two-item queue parts the matching front from the back
// the result register holds one item while out_stall is high, the queue takes up to two more
// reset: asynchronous, clears patterns, matching state, command fifo pointers and flags
// top level of the packet pattern classifier
`default_nettype none
`include "assert_macros.svh"

module packet_pattern_classifier_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [1:0]                       action,
    input  wire logic [ppc_pkg::BYTE_W-1:0]       data_byte,
    input  wire logic                             last_byte,
    input  wire logic [ppc_pkg::COMMAND_BITS-1:0] command_id,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [2:0]                            kind,
    output logic [2:0]                            verdict,
    output logic [ppc_pkg::COMMAND_BITS-1:0]      command_out,
    output logic                                  pending_flag,
    output logic                                  response_seen,
    output logic [ppc_pkg::COUNT_W-1:0]           queue_count,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ppc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ppc_pkg::PAT_W-1:0]        cfg_data
);
    import ppc_pkg::*;

    pat_array_t      pat_reg;
    logic [NPAT-1:0] enable;
    logic            accept;
    op_t             front_op;
    op_t             head_op;
    logic            link_full;
    logic            head_valid;
    logic            head_pop;
    res_t            res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= '0;
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(NPAT)))
        begin
            pat_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NPAT; k++)
        begin
            enable[k] = pat_en(pat_reg[k]);
        end
    end

    assign in_stall = link_full;
    assign accept   = in_valid && !link_full;

    ppc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (action),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .command_id (command_id),
        .patterns   (pat_reg),
        .op         (front_op)
    );

    ppc_link u_link (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_op    (front_op),
        .full       (link_full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    ppc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (head_valid),
        .op        (head_op),
        .op_pop    (head_pop),
        .enable    (enable),
        .res_valid (out_valid),
        .res_stall (out_stall),
        .res       (res)
    );

    assign kind          = res.kind;
    assign verdict       = res.verdict;
    assign command_out   = res.cmd;
    assign pending_flag  = res.pending;
    assign response_seen = res.resp;
    assign queue_count   = res.count;

    // queued commands keep the transmit pending flag up
    `PPC_ASSERT(a_pending_with_fill, clk, rst_n,
        out_valid && (queue_count != '0) |-> pending_flag)

    // busy verdict only while a transmit is pending
    `PPC_ASSERT(a_busy_needs_pending, clk, rst_n,
        out_valid && (kind == KIND_VERDICT) && (verdict == VERD_BUSY) |-> pending_flag)

    // verdict and command fields stay zero outside their own kinds
    `PPC_NEVER(a_stray_fields, clk, rst_n,
        out_valid && (((kind != KIND_VERDICT) && (verdict != VERD_BUSY))
        || ((kind != KIND_POPPED) && (command_out != '0))))

endmodule

`default_nettype wire
